// ----- design/ddm_pkg.sv -----
// Shared types and constants for the differential-drive mixer with slew limiting.
// No dependencies; used by every module of the block by scoped reference.
package ddm_pkg;

    localparam int DIGIT_W = 4;
    localparam int IN_W    = 16;
    localparam int YT_W    = 17;
    localparam int CMD_W   = 19;
    localparam int MULT_W  = 12;
    localparam int LIMIT_W = 31;
    localparam int RPM_W   = 32;

    localparam logic signed [RPM_W-1:0] RPM_MAX = {1'b0, {(RPM_W-1){1'b1}}};
    localparam logic signed [RPM_W-1:0] RPM_MIN = {1'b1, {(RPM_W-1){1'b0}}};

    localparam logic [11:0] RPM_MULTIPLIER_RESET = 12'd500;

    typedef enum logic
    {
        REG_RPM_MULTIPLIER = 1'b0,
        REG_RPM_STEP_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_YAW,
        S_MIX,
        S_SIDE,
        S_SLEW,
        S_COMMIT
    } state_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } mul_ctl_t;

    typedef struct packed
    {
        logic calc;
        logic commit;
    } slew_ctl_t;

endpackage

// ----- design/diff_drive_mixer_slew_limit.sv -----
// Differential-drive mixer: deadzone, yaw mix, rpm gain and per-side slew limit.
// Depends on ddm_pkg, ddm_digit_mul and ddm_slew.
// Sequence from accept to m_axis_tvalid: yaw multiply, mix, rpm-gain multiply, slew and commit;
// both multipliers work in 4-bit digit steps, and commit waits while the output is full.
// An enabled item must commit before the next is accepted; disabled items are taken in idle.
// Reset: held rpm cleared, gain 500, step limit 0, FSM idle, output empty.
module diff_drive_mixer_slew_limit
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // forward_speed[15:0], yaw_rate[31:16]
    input  logic        s_axis_tuser,   // wheels_enabled
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // right_rpm[31:0], left_rpm[63:32]
);

    localparam int D            = ddm_pkg::DIGIT_W;
    localparam int IN_W         = ddm_pkg::IN_W;
    localparam int YT_W         = ddm_pkg::YT_W;
    localparam int CMD_W        = ddm_pkg::CMD_W;
    localparam int MULT_W       = ddm_pkg::MULT_W;
    localparam int RPM_W        = ddm_pkg::RPM_W;
    localparam int DEADZONE_Q   = ((5 << FRAC_BITS) + 50) / 100;
    localparam int YAW_MIX_Q    = ((6 << FRAC_BITS) + 5) / 10;
    localparam int HT_W         = $clog2(YAW_MIX_Q + 1);
    localparam int YAW_STEPS    = (HT_W + D - 1) / D;
    localparam int SIDE_STEPS   = (MULT_W + D - 1) / D;
    localparam int YAW_PW       = IN_W + 1 + YAW_STEPS * D;
    localparam int SIDE_PW      = CMD_W + 1 + SIDE_STEPS * D;
    localparam int MAX_STEPS    = (YAW_STEPS > SIDE_STEPS) ? YAW_STEPS : SIDE_STEPS;
    localparam int CNT_W        = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    function automatic logic signed [IN_W-1:0] deadzone(input logic signed [IN_W-1:0] v);
        logic [IN_W:0] mag;
        mag = v[IN_W-1] ? (IN_W+1)'(-(IN_W+1)'(v)) : (IN_W+1)'(v);
        deadzone = (mag < (IN_W+1)'(DEADZONE_Q)) ? '0 : v;
    endfunction

    ddm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [MULT_W-1:0]          mult_reg;
    logic [ddm_pkg::LIMIT_W-1:0] limit_reg;

    logic signed [IN_W-1:0]     lin_reg;
    logic                       m_valid_reg;
    logic [63:0]                m_data_reg;

    ddm_pkg::mul_ctl_t  yaw_ctl, side_ctl;
    ddm_pkg::slew_ctl_t slew_ctl;
    logic               accept;
    logic               out_free;
    logic               out_load;

    logic signed [YAW_PW-1:0]  yaw_prod;
    logic signed [SIDE_PW-1:0] right_prod, left_prod;
    logic signed [YAW_PW:0]    yt_sum, yt_shift;
    logic signed [YT_W-1:0]    yaw_term;
    logic signed [CMD_W-1:0]   lin_ext, yt_ext, right_mix, left_mix;
    logic signed [RPM_W-1:0]   right_target, left_target;
    logic signed [RPM_W-1:0]   right_held, left_held, right_next, left_next;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg  <= ddm_pkg::RPM_MULTIPLIER_RESET;
            limit_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (ddm_pkg::reg_index_t'(cfg_index))
                ddm_pkg::REG_RPM_MULTIPLIER: mult_reg  <= cfg_data[MULT_W-1:0];
                ddm_pkg::REG_RPM_STEP_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddm_pkg::S_IDLE:
                if (accept && s_axis_tuser)
                    state_next = ddm_pkg::S_YAW;
            ddm_pkg::S_YAW:
                if (cnt_reg == CNT_W'(YAW_STEPS - 1))
                    state_next = ddm_pkg::S_MIX;
            ddm_pkg::S_MIX:
                state_next = ddm_pkg::S_SIDE;
            ddm_pkg::S_SIDE:
                if (cnt_reg == CNT_W'(SIDE_STEPS - 1))
                    state_next = ddm_pkg::S_SLEW;
            ddm_pkg::S_SLEW:
                state_next = ddm_pkg::S_COMMIT;
            ddm_pkg::S_COMMIT:
                if (out_free)
                    state_next = ddm_pkg::S_IDLE;
            default:
                state_next = ddm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready   = 1'b0;
        yaw_ctl         = '0;
        side_ctl        = '0;
        slew_ctl        = '0;
        out_load        = 1'b0;
        case (state_reg)
            ddm_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                yaw_ctl.load  = accept && s_axis_tuser;
            end
            ddm_pkg::S_YAW:
                yaw_ctl.step = 1'b1;
            ddm_pkg::S_MIX:
                side_ctl.load = 1'b1;
            ddm_pkg::S_SIDE:
                side_ctl.step = 1'b1;
            ddm_pkg::S_SLEW:
                slew_ctl.calc = 1'b1;
            ddm_pkg::S_COMMIT:
            begin
                slew_ctl.commit = out_free;
                out_load        = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if ((state_reg == ddm_pkg::S_YAW && cnt_reg != CNT_W'(YAW_STEPS - 1)) ||
            (state_reg == ddm_pkg::S_SIDE && cnt_reg != CNT_W'(SIDE_STEPS - 1)))
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddm_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (yaw_ctl.load)
            lin_reg <= deadzone(s_axis_tdata[15:0]);
    end

    ddm_digit_mul
    #(
        .AW (IN_W),
        .BW (HT_W)
    )
    u_yaw_mul
    (
        .clk  (clk),
        .ctl  (yaw_ctl),
        .a    (deadzone(s_axis_tdata[31:16])),
        .b    (HT_W'(YAW_MIX_Q)),
        .prod (yaw_prod)
    );

    // round half up, then floor shift
    always_comb
    begin
        yt_sum    = {yaw_prod[YAW_PW-1], yaw_prod} + (YAW_PW+1)'(2 ** (FRAC_BITS - 1));
        yt_shift  = yt_sum >>> FRAC_BITS;
        yaw_term  = yt_shift[YT_W-1:0];
        lin_ext   = CMD_W'(lin_reg);
        yt_ext    = CMD_W'(yaw_term);
        right_mix = -(lin_ext + yt_ext);
        left_mix  = yt_ext - lin_ext;
    end

    ddm_digit_mul
    #(
        .AW (CMD_W),
        .BW (MULT_W)
    )
    u_right_mul
    (
        .clk  (clk),
        .ctl  (side_ctl),
        .a    (right_mix),
        .b    (mult_reg),
        .prod (right_prod)
    );

    ddm_digit_mul
    #(
        .AW (CMD_W),
        .BW (MULT_W)
    )
    u_left_mul
    (
        .clk  (clk),
        .ctl  (side_ctl),
        .a    (left_mix),
        .b    (mult_reg),
        .prod (left_prod)
    );

    assign right_target = right_prod[RPM_W-1:0];
    assign left_target  = left_prod[RPM_W-1:0];

    ddm_slew u_right_slew
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (slew_ctl),
        .target     (right_target),
        .step_limit (limit_reg),
        .held       (right_held),
        .held_next  (right_next)
    );

    ddm_slew u_left_slew
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (slew_ctl),
        .target     (left_target),
        .step_limit (limit_reg),
        .held       (left_held),
        .held_next  (left_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= {left_next, right_next};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_held_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ddm_pkg::S_COMMIT && out_free) |=> $stable(right_held) && $stable(left_held))
        else $error("held rpm changed outside commit");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ddm_pkg::S_COMMIT))
        else $error("output valid raised without commit");

    a_enabled_starts_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser) |=> state_reg == ddm_pkg::S_YAW && cnt_reg == '0)
        else $error("enabled command did not start the yaw multiply");

    a_side_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ddm_pkg::S_SIDE |-> cnt_reg < CNT_W'(SIDE_STEPS))
        else $error("side multiply step count overrun");

endmodule

// ----- design/ddm_digit_mul.sv -----
// Digit-serial signed-by-unsigned multiplier, one DIGIT_W-bit digit of b per step.
// Depends on ddm_pkg for the digit width and the control struct.
module ddm_digit_mul
#(
    parameter int AW = 16,
    parameter int BW = 12
)
(
    input  logic                clk,
    input  ddm_pkg::mul_ctl_t   ctl,
    input  logic signed [AW-1:0] a,
    input  logic [BW-1:0]       b,
    output logic signed [AW+(((BW+ddm_pkg::DIGIT_W-1)/ddm_pkg::DIGIT_W)*ddm_pkg::DIGIT_W):0] prod
);

    localparam int D     = ddm_pkg::DIGIT_W;
    localparam int STEPS = (BW + D - 1) / D;
    localparam int BPAD  = STEPS * D;

    logic signed [AW-1:0] a_reg;
    logic [BPAD-1:0]      b_reg;
    logic signed [AW:0]   hi_reg;
    logic [BPAD-1:0]      lo_reg;

    logic [D-1:0]         digit;
    logic signed [AW+D:0] pp;
    logic signed [AW+D:0] acc_sum;

    always_comb
    begin
        digit   = b_reg[D-1:0];
        pp      = (AW+D+1)'(a_reg) * (AW+D+1)'($signed({1'b0, digit}));
        acc_sum = pp + (AW+D+1)'(hi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg  <= a;
            b_reg  <= BPAD'(b);
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (ctl.step)
        begin
            b_reg  <= b_reg >> D;
            hi_reg <= acc_sum[AW+D:D];
            lo_reg <= {acc_sum[D-1:0], lo_reg[BPAD-1:D]};
        end
    end

    assign prod = {hi_reg, lo_reg};

endmodule

// ----- design/ddm_slew.sv -----
// Per-side rpm slew limiter: clamps the step toward the target (no clamp when the limit is 0) and holds the rpm.
// Depends on ddm_pkg for widths, saturation limits and the control struct.
module ddm_slew
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ddm_pkg::slew_ctl_t               ctl,
    input  logic signed [ddm_pkg::RPM_W-1:0] target,
    input  logic [ddm_pkg::LIMIT_W-1:0]      step_limit,
    output logic signed [ddm_pkg::RPM_W-1:0] held,
    output logic signed [ddm_pkg::RPM_W-1:0] held_next
);

    localparam int W = ddm_pkg::RPM_W;

    logic signed [W-1:0] held_reg;
    logic signed [W:0]   delta_reg;
    logic signed [W:0]   diff;
    logic signed [W:0]   lim;
    logic signed [W:0]   delta;
    logic signed [W+1:0] sum;

    always_comb
    begin
        diff  = (W+1)'(target) - (W+1)'(held_reg);
        lim   = $signed({2'b00, step_limit});
        delta = diff;
        if (step_limit != '0)
        begin
            if (diff > lim)
                delta = lim;
            else if (diff < -lim)
                delta = -lim;
        end
    end

    always_comb
    begin
        sum = (W+2)'(held_reg) + (W+2)'(delta_reg);
        if (sum > (W+2)'(ddm_pkg::RPM_MAX))
            held_next = ddm_pkg::RPM_MAX;
        else if (sum < (W+2)'(ddm_pkg::RPM_MIN))
            held_next = ddm_pkg::RPM_MIN;
        else
            held_next = sum[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
            delta_reg <= delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (ctl.commit)
            held_reg <= held_next;
    end

    assign held = held_reg;

endmodule

// ----- tb/ddm_checker.sv -----
`timescale 1ns / 100ps
// Checker for the differential-drive mixer: tracks register writes, predicts wheel rpm
// for each accepted command and compares every output transaction in order.
// Depends on ddm_pkg for register indexes, reset values and rpm limits.
module ddm_checker
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // forward_speed[15:0], yaw_rate[31:16]
    input  logic        s_tuser,    // wheels_enabled
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // right_rpm[31:0], left_rpm[63:32]
    output int          mismatches,
    output int          outstanding
);

    localparam longint DEADBAND = ((longint'(5) << FRAC_BITS) + 50) / 100;
    localparam longint YAW_MIX  = ((longint'(6) << FRAC_BITS) + 5) / 10;

    typedef struct
    {
        logic signed [31:0] right;
        logic signed [31:0] left;
    } wheel_rpm_t;

    wheel_rpm_t         rpm_q[$];
    logic [11:0]        gain;
    logic [30:0]        step_cap;
    logic signed [31:0] right_held;
    logic signed [31:0] left_held;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(ddm_pkg::RPM_MAX))
            return ddm_pkg::RPM_MAX;
        if (v < longint'(ddm_pkg::RPM_MIN))
            return ddm_pkg::RPM_MIN;
        return v[31:0];
    endfunction

    function automatic longint apply_deadband(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        return (mag < DEADBAND) ? 0 : v;
    endfunction

    function automatic logic signed [31:0] slew_toward(input logic signed [31:0] held,
                                                       input longint target);
        longint delta;
        longint cap;
        delta = target - longint'(held);
        cap = longint'(step_cap);
        if (cap != 0)
        begin
            if (delta > cap)
                delta = cap;
            if (delta < -cap)
                delta = -cap;
        end
        return clamp32(longint'(held) + delta);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wheel_rpm_t want;
        longint     lin;
        longint     yaw;
        longint     yaw_term;
        if (!rst_n)
        begin
            gain        = ddm_pkg::RPM_MULTIPLIER_RESET;
            step_cap    = '0;
            right_held  = '0;
            left_held   = '0;
            mismatches  = 0;
            rpm_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == ddm_pkg::REG_RPM_MULTIPLIER)
                    gain = cfg_data[11:0];
                else
                    step_cap = cfg_data;
            end

            if (m_tvalid && m_tready)
            begin
                if (rpm_q.size() == 0)
                    report_mismatch($sformatf("unexpected result right=%0d left=%0d",
                                              $signed(m_tdata[31:0]), $signed(m_tdata[63:32])));
                else
                begin
                    want = rpm_q.pop_front();
                    if ($signed(m_tdata[31:0]) !== want.right)
                        report_mismatch($sformatf("right_rpm got %0d, want %0d",
                                                  $signed(m_tdata[31:0]), want.right));
                    if ($signed(m_tdata[63:32]) !== want.left)
                        report_mismatch($sformatf("left_rpm got %0d, want %0d",
                                                  $signed(m_tdata[63:32]), want.left));
                end
            end

            // disabled commands leave the held rpm alone and produce nothing
            if (s_tvalid && s_tready && s_tuser)
            begin
                lin = apply_deadband(longint'($signed(s_tdata[15:0])));
                yaw = apply_deadband(longint'($signed(s_tdata[31:16])));
                yaw_term = (yaw * YAW_MIX + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                right_held = slew_toward(right_held,
                                         longint'(clamp32(-(lin + yaw_term) * longint'(gain))));
                left_held  = slew_toward(left_held,
                                         longint'(clamp32(-(lin - yaw_term) * longint'(gain))));
                want.right = right_held;
                want.left  = left_held;
                rpm_q.push_back(want);
            end

            outstanding <= rpm_q.size();
        end
    end

endmodule

// ----- tb/tb_diff_drive_mixer_slew_limit.sv -----
`timescale 1ns / 100ps
// Top of the mixer testbench: clock, reset, command stimulus, register phases and verdict.
// Depends on ddm_pkg, diff_drive_mixer_slew_limit and ddm_checker.
module tb_diff_drive_mixer_slew_limit;

    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 75;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_index     = 1'b0;
    logic [30:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    diff_drive_mixer_slew_limit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ddm_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_command(input logic [15:0] fwd, input logic [15:0] yaw,
                                input logic enabled);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, fwd};
        s_axis_tuser  <= enabled;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ddm_pkg::reg_index_t idx, input logic [30:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_speed();
        int pick;
        int near;
        pick = $urandom_range(9);
        near = int'($urandom_range(600)) - 300;
        case (pick)
            0, 1, 2, 3: return 16'($urandom);
            4, 5:       return near[15:0];
            6:          return 16'h7FFF;
            7:          return 16'h8000;
            default:    return 16'h0000;
        endcase
    endfunction

    initial
    begin
        logic [15:0] fwd;
        logic [15:0] yaw;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: gain 500, no slew limit
        send_command(16'h0000, 16'h0000, 1'b1);
        send_command(16'h7FFF, 16'h0000, 1'b1);
        send_command(16'h8000, 16'h0000, 1'b1);
        send_command(16'h0000, 16'h7FFF, 1'b1);   // pure yaw, sides opposite
        send_command(16'h0000, 16'h8000, 1'b1);
        send_command(16'd204,  16'h0000, 1'b1);   // just inside deadband
        send_command(16'd205,  16'h0000, 1'b1);
        send_command(-16'sd204, -16'sd205, 1'b1);
        send_command(-16'sd205, 16'd204, 1'b1);
        send_command(16'h7FFF, 16'h7FFF, 1'b1);
        send_command(16'h8000, 16'h8000, 1'b1);
        send_command(16'h1234, 16'h4321, 1'b0);   // disabled, held rpm unchanged
        send_command(16'h7FFF, 16'h8000, 1'b1);
        send_command(16'hFFFF, 16'hFFFF, 1'b0);
        send_command(16'h8000, 16'h7FFF, 1'b1);
        send_command(16'h0000, 16'd205,  1'b1);
        send_command(16'h0000, -16'sd205, 1'b1);
        send_command(16'h0800, 16'h0F00, 1'b1);
        drain_results();

        // tight slew at maximum gain
        write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'd4095);
        write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'd1);
        send_command(16'h7FFF, 16'h7FFF, 1'b1);
        send_command(16'h8000, 16'h8000, 1'b1);
        send_command(16'h0000, 16'h0000, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            case (ph)
                0:
                begin
                    write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'd4095);
                    write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'd0);
                end
                1:
                begin
                    write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'd0);
                    write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'h7FFFFFFF);
                end
                2:
                begin
                    write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'd1);
                    write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'd1);
                end
                3:
                begin
                    write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'd4095);
                    write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'd250000);
                end
                4:
                begin
                    write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'($urandom_range(4095)));
                    write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'($urandom_range(1 << 20)));
                end
                default:
                begin
                    write_reg(ddm_pkg::REG_RPM_MULTIPLIER, 31'($urandom_range(4095)));
                    write_reg(ddm_pkg::REG_RPM_STEP_LIMIT, 31'($urandom));
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                fwd = pick_speed();
                yaw = pick_speed();
                if ($urandom_range(9) == 0)
                    fwd = 16'h0000;
                send_command(fwd, yaw, $urandom_range(99) < 85);
                if (n == PHASE_ITEMS / 2)
                    drain_results();
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
